### hw/rtl/mlcq_pkg.sv
// Shared types and constants for the multi-level circular queue unit.
// No dependencies; used by mlcq_ctrl, mlcq_store and the top level.
`timescale 1ns / 1ps

package mlcq_pkg;

    // Default sizing
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int LEVEL_COUNT_DEF = 8;
    localparam int DATA_WIDTH_DEF  = 32;

    // Fixed field widths of the stream beats
    localparam int LEVEL_W  = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // Widest level index and pointer the parameter ranges allow
    localparam int LVL_IDX_MAX_W = 6;
    localparam int PTR_MAX_W     = 8;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // Storage access issued by the control for one beat
    typedef struct packed {
        logic                     wr_en;
        logic                     rd_en;
        logic [LVL_IDX_MAX_W-1:0] lvl;
        logic [PTR_MAX_W-1:0]     ptr;
    } mlcq_access_t;

endpackage

### hw/rtl/mlcq_ctrl.sv
// Per-level head/tail pointers and fill counts; decides ok/overflow/underflow.
// Depends on mlcq_pkg.
`timescale 1ns / 1ps

module mlcq_ctrl #(
    parameter int QUEUE_DEPTH = mlcq_pkg::QUEUE_DEPTH_DEF,
    parameter int LEVEL_COUNT = mlcq_pkg::LEVEL_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          opcode,
    input  logic [mlcq_pkg::LEVEL_W-1:0]  level,
    output mlcq_pkg::mlcq_access_t        access,
    output logic [mlcq_pkg::STATUS_W-1:0] status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

    logic [PTR_W-1:0] head_reg  [LEVEL_COUNT];
    logic [PTR_W-1:0] tail_reg  [LEVEL_COUNT];
    logic [CNT_W-1:0] count_reg [LEVEL_COUNT];

    logic [LVL_W+mlcq_pkg::LEVEL_W-1:0] lvl_ext;
    logic [LVL_W-1:0]                   lvl_idx;
    logic                               in_range;
    logic [CNT_W-1:0]                   cnt;
    logic [PTR_W-1:0]                   head_cur;
    logic [PTR_W-1:0]                   tail_cur;
    logic [PTR_W-1:0]                   head_next;
    logic [PTR_W-1:0]                   tail_next;
    logic                               enq_ok;
    logic                               deq_ok;

    always_comb
    begin
        lvl_ext  = (LVL_W + mlcq_pkg::LEVEL_W)'(level);
        in_range = 32'(level) < 32'(LEVEL_COUNT);
        lvl_idx  = in_range ? lvl_ext[LVL_W-1:0] : '0;
        cnt      = count_reg[lvl_idx];
        head_cur = head_reg[lvl_idx];
        tail_cur = tail_reg[lvl_idx];
        // wrap at the last slot
        head_next = (head_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                          : head_cur + PTR_W'(1);
        tail_next = (tail_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                          : tail_cur + PTR_W'(1);
        enq_ok = (opcode == mlcq_pkg::OP_ENQ) && in_range && (cnt != CNT_W'(QUEUE_DEPTH));
        deq_ok = (opcode == mlcq_pkg::OP_DEQ) && in_range && (cnt != '0);

        if (opcode == mlcq_pkg::OP_ENQ)
        begin
            status = enq_ok ? mlcq_pkg::ST_OK : mlcq_pkg::ST_OVERFLOW;
        end
        else
        begin
            status = deq_ok ? mlcq_pkg::ST_OK : mlcq_pkg::ST_UNDERFLOW;
        end

        access.wr_en = en && enq_ok;
        access.rd_en = en && deq_ok;
        access.lvl   = mlcq_pkg::LVL_IDX_MAX_W'(lvl_idx);
        access.ptr   = mlcq_pkg::PTR_MAX_W'((opcode == mlcq_pkg::OP_ENQ) ? tail_cur : head_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVEL_COUNT; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            if (enq_ok)
            begin
                tail_reg[lvl_idx]  <= tail_next;
                count_reg[lvl_idx] <= cnt + CNT_W'(1);
            end
            else if (deq_ok)
            begin
                head_reg[lvl_idx]  <= head_next;
                count_reg[lvl_idx] <= cnt - CNT_W'(1);
            end
        end
    end

endmodule

### hw/rtl/mlcq_store.sv
// Entry memory for all levels, one write or one registered read per beat.
// Depends on mlcq_pkg.
`timescale 1ns / 1ps

module mlcq_store #(
    parameter int QUEUE_DEPTH = mlcq_pkg::QUEUE_DEPTH_DEF,
    parameter int LEVEL_COUNT = mlcq_pkg::LEVEL_COUNT_DEF,
    parameter int DATA_WIDTH  = mlcq_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  mlcq_pkg::mlcq_access_t      access,
    input  logic [mlcq_pkg::WORD_W-1:0] wr_data,
    output logic [mlcq_pkg::WORD_W-1:0] rd_word
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

    logic [DATA_WIDTH-1:0] mem [LEVEL_COUNT][QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] wr_word;
    logic [LVL_W-1:0]      lvl;
    logic [PTR_W-1:0]      ptr;

    assign lvl = access.lvl[LVL_W-1:0];
    assign ptr = access.ptr[PTR_W-1:0];

    generate
        if (DATA_WIDTH >= mlcq_pkg::WORD_W)
        begin : g_wide
            assign wr_word = DATA_WIDTH'(wr_data);
            assign rd_word = rd_data_reg[mlcq_pkg::WORD_W-1:0];
        end
        else
        begin : g_narrow
            assign wr_word = wr_data[DATA_WIDTH-1:0];
            // sign-extend the stored word to the output width
            assign rd_word = {{(mlcq_pkg::WORD_W - DATA_WIDTH){rd_data_reg[DATA_WIDTH-1]}},
                              rd_data_reg};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (access.wr_en)
        begin
            mem[lvl][ptr] <= wr_word;
        end
        if (access.rd_en)
        begin
            rd_data_reg <= mem[lvl][ptr];
        end
    end

endmodule

### hw/rtl/multi_level_circular_queues_unit.sv
// Top level of the per-priority circular FIFO bank: input register, result register.
// Depends on mlcq_pkg, mlcq_ctrl and mlcq_store.
`timescale 1ns / 1ps

// Channel   | Dir | tdata                    | tuser
// s_axis    | in  | [31:0] data_in           | [0] opcode, [3:1] level
// m_axis    | out | [31:0] data_out          | [1:0] status
//
// One beat per cycle sustained while m_axis is not stalled; each beat passes the input
// register, then pointer lookup and the memory port into the result register.
// Consecutive beats on the same level see each other's pointer updates at once.
// Reset clears pointers and fill counts; the entry memory is not cleared.
// A stalled m_axis holds the result; s_axis_tready drops while the input register
// is full and the result is stalled.

module multi_level_circular_queues_unit #(
    parameter int QUEUE_DEPTH = mlcq_pkg::QUEUE_DEPTH_DEF,
    parameter int LEVEL_COUNT = mlcq_pkg::LEVEL_COUNT_DEF,
    parameter int DATA_WIDTH  = mlcq_pkg::DATA_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_in
    input  logic [3:0]  s_axis_tuser,   // [0] opcode, [3:1] level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] data_out
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic                              in_valid_reg;
    logic                              opcode_reg;
    logic [mlcq_pkg::LEVEL_W-1:0]      level_reg;
    logic [mlcq_pkg::WORD_W-1:0]       data_reg;

    logic                              out_valid_reg;
    logic [mlcq_pkg::STATUS_W-1:0]     status_reg;
    logic                              deq_ok_reg;

    logic                              process;
    mlcq_pkg::mlcq_access_t            access;
    logic [mlcq_pkg::STATUS_W-1:0]     status;
    logic [mlcq_pkg::WORD_W-1:0]       rd_word;

    assign process       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || process;

    mlcq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (process),
        .opcode (opcode_reg),
        .level  (level_reg),
        .access (access),
        .status (status)
    );

    mlcq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LEVEL_COUNT (LEVEL_COUNT),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .access  (access),
        .wr_data (data_reg),
        .rd_word (rd_word)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            opcode_reg <= s_axis_tuser[0];
            level_reg  <= s_axis_tuser[3:1];
            data_reg   <= s_axis_tdata;
        end
    end

    // result register; read data sits in the store's read register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            status_reg <= status;
            deq_ok_reg <= access.rd_en;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = deq_ok_reg ? rd_word : '0;
    assign m_axis_tuser  = status_reg;

`ifndef SYNTHESIS
    a_fail_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != mlcq_pkg::ST_OK)) |-> (m_axis_tdata == '0))
        else $error("failed operation carries nonzero data");

    a_process_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> m_axis_tvalid)
        else $error("processed beat produced no result");

    a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(access.wr_en && access.rd_en))
        else $error("write and read issued in the same cycle");
`endif

endmodule

### sim/mlcq_queue_checker.sv
// Checker for the multi-level circular queue unit: models every level's FIFO,
// predicts one reply per input beat and compares it with each output beat.
// Depends on mlcq_pkg for field widths, opcodes and status codes.
`timescale 1ns / 1ps

module mlcq_queue_checker #(
    parameter int QUEUE_DEPTH = mlcq_pkg::QUEUE_DEPTH_DEF,
    parameter int LEVEL_COUNT = mlcq_pkg::LEVEL_COUNT_DEF,
    parameter int DATA_WIDTH  = mlcq_pkg::DATA_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_in
    input  logic [3:0]  s_axis_tuser,   // [0] opcode, [3:1] level
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] data_out
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [mlcq_pkg::WORD_W-1:0]   data;
        logic [mlcq_pkg::STATUS_W-1:0] status;
    } queue_reply_t;

    logic [DATA_WIDTH-1:0] word_bank [LEVEL_COUNT][QUEUE_DEPTH];
    int unsigned           head_ptr  [LEVEL_COUNT] = '{default: 0};
    int unsigned           tail_ptr  [LEVEL_COUNT] = '{default: 0};
    int unsigned           occupancy [LEVEL_COUNT] = '{default: 0};
    queue_reply_t          awaited_replies [$];
    int                    mismatches = 0;

    function automatic int unsigned next_slot(input int unsigned ptr);
        return (ptr + 1 >= QUEUE_DEPTH) ? 0 : ptr + 1;
    endfunction

    // Applies one enqueue/dequeue to the model and returns the reply it yields.
    function automatic queue_reply_t apply_queue_op(input logic op,
                                                    input logic [mlcq_pkg::LEVEL_W-1:0] lvl,
                                                    input logic [mlcq_pkg::WORD_W-1:0] word);
        queue_reply_t                       reply;
        int unsigned                        idx;
        logic signed [DATA_WIDTH-1:0]       stored;
        logic signed [mlcq_pkg::WORD_W-1:0] widened;
        reply.data   = '0;
        reply.status = mlcq_pkg::ST_OK;
        idx          = 32'(lvl);
        if (op == mlcq_pkg::OP_ENQ)
        begin
            // out-of-range levels act as permanently full
            if (idx >= LEVEL_COUNT || occupancy[idx] >= QUEUE_DEPTH)
                reply.status = mlcq_pkg::ST_OVERFLOW;
            else
            begin
                word_bank[idx][tail_ptr[idx]] = word[DATA_WIDTH-1:0];
                tail_ptr[idx]  = next_slot(tail_ptr[idx]);
                occupancy[idx] = occupancy[idx] + 1;
            end
        end
        else
        begin
            if (idx >= LEVEL_COUNT || occupancy[idx] == 0)
                reply.status = mlcq_pkg::ST_UNDERFLOW;
            else
            begin
                stored         = word_bank[idx][head_ptr[idx]];
                widened        = stored;
                reply.data     = widened;
                head_ptr[idx]  = next_slot(head_ptr[idx]);
                occupancy[idx] = occupancy[idx] - 1;
            end
        end
        return reply;
    endfunction

    always @(posedge clk)
    begin : monitor
        queue_reply_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_replies.push_back(apply_queue_op(s_axis_tuser[0], s_axis_tuser[3:1],
                                                         s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    mismatches++;
                    $error("result beat with no reply outstanding: data_out=%h status=%0d",
                           m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (m_axis_tdata !== want.data)
                    begin
                        mismatches++;
                        $error("data_out: expected %h, actual %h", want.data, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        mismatches++;
                        $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= awaited_replies.size();
    end

endmodule

### sim/testbench.sv
// Top of the queue unit testbench: clock, reset, beat stimulus, backpressure
// and the verdict. Depends on mlcq_pkg, the DUT and mlcq_queue_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_BEATS  = 450;
    localparam int TAIL_CYCLES  = 10;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] data_in
    logic [3:0]  s_axis_tuser  = '0;   // [0] opcode, [3:1] level
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;         // [31:0] data_out
    logic [1:0]  m_axis_tuser;         // [1:0] status

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;

    int send_pcts [4] = '{0, 58, 0, 33};
    int recv_pcts [4] = '{0, 0, 58, 33};

    multi_level_circular_queues_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mlcq_queue_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Sends one beat; valid stays high afterwards unless the next call idles or drains.
    task automatic push_beat(input logic op, input logic [mlcq_pkg::LEVEL_W-1:0] lvl,
                             input logic [31:0] word);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= {lvl, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        logic [31:0] patterns [8];
        patterns = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE};
        push_beat(mlcq_pkg::OP_DEQ, 3'd7, 32'hDEAD_BEEF);          // empty queue
        for (int i = 0; i < 8; i++)
            push_beat(mlcq_pkg::OP_ENQ, 3'd0, patterns[i]);        // fill, tail wraps
        push_beat(mlcq_pkg::OP_ENQ, 3'd0, 32'h1234_5678);          // full queue
        for (int i = 0; i < 8; i++)
            push_beat(mlcq_pkg::OP_DEQ, 3'd0, 32'hFFFF_FFFF);      // drain, head wraps
        push_beat(mlcq_pkg::OP_DEQ, 3'd0, 32'h0);
        push_beat(mlcq_pkg::OP_ENQ, 3'd7, 32'h7FFF_FFFF);
        push_beat(mlcq_pkg::OP_DEQ, 3'd7, 32'h0);
    endtask

    // Bursts favor one hot level and lean toward filling or draining,
    // so queues regularly hit full and empty.
    task automatic run_random(input int beats);
        int                           enq_bias;
        int                           hot_level;
        logic                         op;
        logic [mlcq_pkg::LEVEL_W-1:0] lvl;
        logic [31:0]                  word;
        enq_bias  = 50;
        hot_level = 0;
        for (int i = 0; i < beats; i++)
        begin
            if (i % 32 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       enq_bias = 25;
                    1:       enq_bias = 75;
                    default: enq_bias = 50;
                endcase
                hot_level = $urandom_range(0, 7);
            end
            op  = ($urandom_range(0, 99) < enq_bias) ? mlcq_pkg::OP_ENQ : mlcq_pkg::OP_DEQ;
            lvl = ($urandom_range(0, 99) < 70) ? mlcq_pkg::LEVEL_W'(hot_level)
                                               : mlcq_pkg::LEVEL_W'($urandom_range(0, 7));
            case ($urandom_range(0, 15))
                0:       word = 32'h8000_0000;
                1:       word = 32'h7FFF_FFFF;
                default: word = $urandom;
            endcase
            push_beat(op, lvl, word);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain_replies();
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            run_random(PHASE_BEATS);
            // sender holds off until every reply is back
            drain_replies();
        end
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule
